// ----- rtl/csp_pkg.sv -----
// Shared types, constants and the write-word builder for the register planner.
`default_nettype none
package csp_pkg;

   localparam int XTAL_W   = 26;
   localparam int TGT_W    = 30;
   localparam int FREQ_W   = 32;
   localparam int QUOT_W   = 30;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 30;
   localparam int IDX_W    = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_CRYSTAL = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET  = 1'd1;

   localparam logic [XTAL_W-1:0] CRYSTAL_RESET = 26'd25000000;
   localparam logic [TGT_W-1:0]  TARGET_RESET  = 30'd900000000;

   localparam logic [19:0] DENOM      = 20'hFFFFF;
   localparam logic [7:0]  PLLA_BASE  = 8'd26;
   localparam logic [7:0]  MS0_BASE   = 8'd42;
   localparam logic [7:0]  CLK0_CTRL  = 8'd16;
   localparam logic [7:0]  CLK0_VALUE = 8'h4F;
   localparam logic [11:0] DIV_MIN    = 12'd4;
   localparam logic [11:0] DIV_MAX    = 12'd2048;
   localparam logic [17:0] P1_OFFSET  = 18'd512;
   localparam logic [IDX_W-1:0] LAST_IDX = 5'd16;

   typedef struct packed {
      logic        err;
      logic [17:0] pll_p1;
      logic [19:0] pll_p2;
      logic [17:0] ms_p1;
   } csp_job_type;

   typedef struct packed {
      logic              start;
      logic [31:0]       rem;
      logic [QUOT_W-1:0] bits;
      logic [31:0]       divisor;
      logic [3:0]        cycles;
   } csp_div_req_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quot;
      logic [31:0]       rem;
   } csp_div_rsp_type;

   typedef struct packed {
      logic [7:0] addr;
      logic [7:0] data;
      logic       last;
      logic       err;
   } csp_word_type;

   function automatic logic [7:0] csp_byte(input logic [2:0] k, input logic [17:0] p1,
                                           input logic [19:0] p2, input logic [19:0] p3);
      logic [7:0] b;
      unique case (k)
         3'd0: b = p3[15:8];
         3'd1: b = p3[7:0];
         3'd2: b = {6'd0, p1[17:16]};
         3'd3: b = p1[15:8];
         3'd4: b = p1[7:0];
         3'd5: b = {p3[19:16], p2[19:16]};
         3'd6: b = p2[15:8];
         default: b = p2[7:0];
      endcase
      return b;
   endfunction

   function automatic csp_word_type csp_word(input csp_job_type job, input logic [IDX_W-1:0] idx);
      csp_word_type w;
      w = '0;
      if (job.err) begin
         w.last = 1'b1;
         w.err  = 1'b1;
      end else if (idx == LAST_IDX) begin
         w.addr = CLK0_CTRL;
         w.data = CLK0_VALUE;
         w.last = 1'b1;
      end else if (idx[3]) begin
         w.addr = MS0_BASE + {5'd0, idx[2:0]};
         w.data = csp_byte(idx[2:0], job.ms_p1, 20'd0, 20'd1);
      end else begin
         w.addr = PLLA_BASE + {5'd0, idx[2:0]};
         w.data = csp_byte(idx[2:0], job.pll_p1, job.pll_p2, DENOM);
      end
      return w;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/csp_div.sv -----
// Shared restoring divider, two quotient bits per cycle.
`default_nettype none
module csp_div (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire csp_pkg::csp_div_req_type req,
   output csp_pkg::csp_div_rsp_type      rsp
);
   import csp_pkg::*;

   logic [31:0]       rem_ff, d_ff;
   logic [QUOT_W-1:0] bits_ff;
   logic [3:0]        cnt_ff;
   logic              busy_ff, done_ff;

   logic [32:0] t1, t2, r1, r2;
   logic        q1, q2;

   always_comb begin
      t1 = {rem_ff, bits_ff[QUOT_W-1]};
      q1 = t1 >= {1'b0, d_ff};
      r1 = q1 ? t1 - {1'b0, d_ff} : t1;
      t2 = {r1[31:0], bits_ff[QUOT_W-2]};
      q2 = t2 >= {1'b0, d_ff};
      r2 = q2 ? t2 - {1'b0, d_ff} : t2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && cnt_ff == 4'd1;
         if (req.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == 4'd1) begin
            busy_ff <= 1'b0;
         end
      end
      if (req.start) begin
         rem_ff  <= req.rem;
         bits_ff <= req.bits;
         d_ff    <= req.divisor;
         cnt_ff  <= req.cycles;
      end else if (busy_ff) begin
         rem_ff  <= r2[31:0];
         bits_ff <= {bits_ff[QUOT_W-3:0], q1, q2};
         cnt_ff  <= cnt_ff - 4'd1;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quot = bits_ff;
   assign rsp.rem  = rem_ff;

endmodule
`default_nettype wire

// ----- rtl/csp_front.sv -----
// Front end: takes a frequency word and works out the divider and PLL parameters.
`default_nettype none
module csp_front (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_push,
   input  wire logic [csp_pkg::FREQ_W-1:0]        req_freq_hz,
   output logic                                   req_full,
   input  wire logic [csp_pkg::XTAL_W-1:0]        xtal,
   input  wire logic [csp_pkg::TGT_W-1:0]         target,
   input  wire logic                              q_full,
   output logic                                   q_push,
   output csp_pkg::csp_job_type                   q_job
);
   import csp_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIV1 = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_ST2  = 3'd3;
   localparam logic [2:0] S_DIV2 = 3'd4;
   localparam logic [2:0] S_DIV3 = 3'd5;
   localparam logic [2:0] S_FRAC = 3'd6;
   localparam logic [2:0] S_PUSH = 3'd7;

   logic [2:0]        state_ff;
   logic              pend_v_ff;
   logic [FREQ_W-1:0] pend_ff, freq_ff;
   logic [11:0]       dvd_ff;
   logic [29:0]       pll_ff, mult_ff;
   logic [19:0]       num_ff;
   csp_job_type       job_ff;

   csp_div_req_type div_req;
   csp_div_rsp_type div_rsp;

   logic        start_ok;
   logic [29:0] dvd_even;
   logic        dvd_bad;
   logic [45:0] xnum;
   logic [43:0] prod;
   logic [26:0] x7;
   logic [6:0]  fq, frac;
   logic [20:0] fr;
   logic [26:0] p2w;

   csp_div u_div (.clock(clock), .reset(reset), .req(div_req), .rsp(div_rsp));

   always_comb begin
      start_ok = pend_v_ff && pend_ff != '0 && xtal != '0;
      dvd_even = {div_rsp.quot[29:1], 1'b0};
      dvd_bad  = dvd_even < {18'd0, DIV_MIN} || dvd_even > {18'd0, DIV_MAX};
      xnum     = {div_rsp.rem[25:0], 20'd0} - {20'd0, div_rsp.rem[25:0]};
      prod     = dvd_ff * freq_ff;
      x7       = {num_ff, 7'd0};
      fq       = x7[26:20];
      fr       = {1'b0, x7[19:0]} + {14'd0, fq};
      frac     = fq + {6'd0, fr >= {1'b0, DENOM}};
      p2w      = x7 - {frac, 20'd0} + {20'd0, frac};
      div_req  = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start_ok) begin
               div_req.start   = 1'b1;
               div_req.bits    = target;
               div_req.divisor = pend_ff;
               div_req.cycles  = 4'd15;
            end
         end
         S_ST2: begin
            div_req.start   = 1'b1;
            div_req.bits    = pll_ff;
            div_req.divisor = {6'd0, xtal};
            div_req.cycles  = 4'd15;
         end
         S_DIV2: begin
            if (div_rsp.done) begin
               div_req.start   = 1'b1;
               div_req.rem     = {6'd0, xnum[45:20]};
               div_req.bits    = {xnum[19:0], 10'd0};
               div_req.divisor = {6'd0, xtal};
               div_req.cycles  = 4'd10;
            end
         end
         default: div_req = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         pend_v_ff <= 1'b0;
      end else begin
         if (req_push && !pend_v_ff) begin
            pend_v_ff <= 1'b1;
         end else if (state_ff == S_IDLE && pend_v_ff) begin
            pend_v_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: if (pend_v_ff) state_ff <= start_ok ? S_DIV1 : S_PUSH;
            S_DIV1: if (div_rsp.done) state_ff <= dvd_bad ? S_PUSH : S_MUL;
            S_MUL:  state_ff <= S_ST2;
            S_ST2:  state_ff <= S_DIV2;
            S_DIV2: if (div_rsp.done) state_ff <= S_DIV3;
            S_DIV3: if (div_rsp.done) state_ff <= S_FRAC;
            S_FRAC: state_ff <= S_PUSH;
            default: if (!q_full) state_ff <= S_IDLE;
         endcase
      end
      if (req_push && !pend_v_ff) pend_ff <= req_freq_hz;
      unique case (state_ff)
         S_IDLE: begin
            freq_ff <= pend_ff;
            job_ff  <= {!start_ok, 56'd0};
         end
         S_DIV1: begin
            dvd_ff       <= dvd_even[11:0];
            job_ff.err   <= dvd_bad;
            job_ff.ms_p1 <= {dvd_even[10:0], 7'd0} - P1_OFFSET;
         end
         S_MUL:  pll_ff <= prod[29:0];
         S_DIV2: if (div_rsp.done) mult_ff <= div_rsp.quot;
         S_DIV3: if (div_rsp.done) num_ff <= div_rsp.quot[19:0];
         S_FRAC: begin
            job_ff.pll_p1 <= {mult_ff[10:0], 7'd0} + {11'd0, frac} - P1_OFFSET;
            job_ff.pll_p2 <= p2w[19:0];
         end
         default: ;
      endcase
   end

   assign req_full = pend_v_ff;
   assign q_push   = state_ff == S_PUSH && !q_full;
   assign q_job    = job_ff;

endmodule
`default_nettype wire

// ----- rtl/csp_queue.sv -----
// Two-entry job queue between front and back end.
`default_nettype none
module csp_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire csp_pkg::csp_job_type push_job,
   output logic                      full,
   input  wire logic                 pop,
   output csp_pkg::csp_job_type      pop_job,
   output logic                      empty
);
   import csp_pkg::*;

   csp_job_type mem_ff [2];
   logic        wptr_ff, rptr_ff;
   logic [1:0]  cnt_ff;
   logic        do_push, do_pop;

   assign full    = cnt_ff == 2'd2;
   assign empty   = cnt_ff == 2'd0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_job = mem_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         if (do_push) wptr_ff <= !wptr_ff;
         if (do_pop) rptr_ff <= !rptr_ff;
         cnt_ff <= cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
      if (do_push) mem_ff[wptr_ff] <= push_job;
   end

endmodule
`default_nettype wire

// ----- rtl/csp_back.sv -----
// Back end: plays one job out as its run of register-write words.
`default_nettype none
module csp_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 q_empty,
   input  wire csp_pkg::csp_job_type q_job,
   output logic                      q_pop,
   output logic                      rsp_empty,
   input  wire logic                 rsp_pop,
   output logic [7:0]                rsp_reg_addr,
   output logic [7:0]                rsp_reg_data,
   output logic                      rsp_last_write,
   output logic                      rsp_range_error
);
   import csp_pkg::*;

   logic             busy_ff, out_v_ff;
   logic [IDX_W-1:0] idx_ff;
   csp_job_type      job_ff;
   csp_word_type     out_ff, word_in;
   logic             advance;

   assign word_in = csp_word(job_ff, idx_ff);
   assign advance = !out_v_ff || rsp_pop;
   assign q_pop   = !busy_ff && !q_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         out_v_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         if (busy_ff && advance) begin
            out_v_ff <= 1'b1;
            if (word_in.last) busy_ff <= 1'b0;
            idx_ff <= idx_ff + 5'd1;
         end else if (rsp_pop) begin
            out_v_ff <= 1'b0;
         end
         if (q_pop) begin
            busy_ff <= 1'b1;
            idx_ff  <= '0;
         end
      end
      if (q_pop) job_ff <= q_job;
      if (busy_ff && advance) out_ff <= word_in;
   end

   assign rsp_empty       = !out_v_ff;
   assign rsp_reg_addr    = out_ff.addr;
   assign rsp_reg_data    = out_ff.data;
   assign rsp_last_write  = out_ff.last;
   assign rsp_range_error = out_ff.err;

   a_err_last: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_range_error |-> rsp_last_write)
      else $error("error word not marked last");
   a_last_addr: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_last_write && !rsp_range_error |-> rsp_reg_addr == CLK0_CTRL)
      else $error("final write not to clock control");
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> idx_ff <= LAST_IDX)
      else $error("word index past end of run");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !busy_ff)
      else $error("job taken while a run is in progress");

endmodule
`default_nettype wire

// ----- rtl/clock_synth_register_planner_top.sv -----
// Top level of the clock synthesizer register planner.
// Each frequency word pushed in yields seventeen register-write words (PLL-A 26..33,
// multisynth-0 42..49, then clock control 16), or one error word when the frequency
// is zero, the crystal is zero or the even divider falls outside 4..2048. Working
// out one frequency uses the shared two-bit-per-cycle divider for three divisions
// in turn; the seventeen writes then go out one per cycle while rsp_pop takes them,
// and the back end plays one run while the next is worked out. The user must write
// crystal and PLL ceiling registers via csr_ only while idle; the block won't check.
`default_nettype none
module clock_synth_register_planner_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_push,
   output logic                               req_full,
   input  wire logic [31:0]                   req_freq_hz,
   output logic                               rsp_empty,
   input  wire logic                          rsp_pop,
   output logic [7:0]                         rsp_reg_addr,
   output logic [7:0]                         rsp_reg_data,
   output logic                               rsp_last_write,
   output logic                               rsp_range_error,
   input  wire logic                          csr_write_en,
   input  wire logic [csp_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [csp_pkg::CSR_DAT_W-1:0] csr_data
);
   import csp_pkg::*;

   logic [XTAL_W-1:0] xtal_ff;
   logic [TGT_W-1:0]  target_ff;
   logic              q_push, q_full, q_pop, q_empty;
   csp_job_type       push_job, pop_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         xtal_ff   <= CRYSTAL_RESET;
         target_ff <= TARGET_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_CRYSTAL: xtal_ff <= csr_data[XTAL_W-1:0];
            default:     target_ff <= csr_data;
         endcase
      end
   end

   csp_front u_front (
      .clock(clock), .reset(reset), .req_push(req_push), .req_freq_hz(req_freq_hz),
      .req_full(req_full), .xtal(xtal_ff), .target(target_ff), .q_full(q_full),
      .q_push(q_push), .q_job(push_job)
   );

   csp_queue u_queue (
      .clock(clock), .reset(reset), .push(q_push), .push_job(push_job), .full(q_full),
      .pop(q_pop), .pop_job(pop_job), .empty(q_empty)
   );

   csp_back u_back (
      .clock(clock), .reset(reset), .q_empty(q_empty), .q_job(pop_job), .q_pop(q_pop),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_reg_addr(rsp_reg_addr),
      .rsp_reg_data(rsp_reg_data), .rsp_last_write(rsp_last_write),
      .rsp_range_error(rsp_range_error)
   );

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the clock synthesizer register planner.
`default_nettype none
module tb_top;
   import csp_pkg::*;

   localparam int SETTLE_CYCLES = 64;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [31:0] req_freq_hz = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [7:0]  rsp_reg_addr;
   logic [7:0]  rsp_reg_data;
   logic        rsp_last_write;
   logic        rsp_range_error;
   logic        csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_CRYSTAL;
   logic [CSR_DAT_W-1:0] csr_data = '0;

   clock_synth_register_planner_top u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic [XTAL_W-1:0] crystal_hz = CRYSTAL_RESET;
   logic [TGT_W-1:0]  target_hz  = TARGET_RESET;
   csp_word_type      pending_writes[$];
   int                error_count = 0;
   int                send_idle_pct = 0;
   int                recv_idle_pct = 0;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("tb: mismatch %s got %0d want %0d", what, got, want);
      error_count++;
   endtask

   function automatic void queue_write(input logic [7:0] a, input logic [7:0] d,
                                       input logic last, input logic err);
      csp_word_type w;
      w.addr = a;
      w.data = d;
      w.last = last;
      w.err  = err;
      pending_writes.push_back(w);
   endfunction

   function automatic void queue_param_block(input logic [7:0] base, input logic [31:0] p1,
                                             input logic [31:0] p2, input logic [31:0] p3);
      queue_write(base + 8'd0, p3[15:8], 1'b0, 1'b0);
      queue_write(base + 8'd1, p3[7:0], 1'b0, 1'b0);
      queue_write(base + 8'd2, {6'd0, p1[17:16]}, 1'b0, 1'b0);
      queue_write(base + 8'd3, p1[15:8], 1'b0, 1'b0);
      queue_write(base + 8'd4, p1[7:0], 1'b0, 1'b0);
      queue_write(base + 8'd5, {p3[19:16], p2[19:16]}, 1'b0, 1'b0);
      queue_write(base + 8'd6, p2[15:8], 1'b0, 1'b0);
      queue_write(base + 8'd7, p2[7:0], 1'b0, 1'b0);
   endfunction

   function automatic void plan_frequency(input logic [31:0] f);
      logic [63:0] divider, pll, mult, remd, num, frac, p1w, p2w;
      logic [31:0] ms_p1;
      if (f == 0 || crystal_hz == 0) begin
         queue_write(8'd0, 8'd0, 1'b1, 1'b1);
         return;
      end
      divider = 64'(target_hz) / 64'(f);
      divider[0] = 1'b0;
      if (divider < 4 || divider > 2048) begin
         queue_write(8'd0, 8'd0, 1'b1, 1'b1);
         return;
      end
      pll  = divider * 64'(f);
      mult = pll / 64'(crystal_hz);
      remd = pll % 64'(crystal_hz);
      num  = (remd * 64'd1048575) / 64'(crystal_hz);
      frac = (64'd128 * num) / 64'd1048575;
      p1w  = 64'd128 * mult + frac - 64'd512;
      p2w  = 64'd128 * num - 64'd1048575 * frac;
      ms_p1 = 32'(64'd128 * divider - 64'd512);
      queue_param_block(PLLA_BASE, p1w[31:0], p2w[31:0], 32'd1048575);
      queue_param_block(MS0_BASE, ms_p1, 32'd0, 32'd1);
      queue_write(CLK0_CTRL, CLK0_VALUE, 1'b1, 1'b0);
   endfunction

   task automatic send_freq(input logic [31:0] f);
      if ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_push    <= 1'b1;
      req_freq_hz <= f;
      do @(posedge clock); while (req_full);
      plan_frequency(f);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] d);
      req_push <= 1'b0;
      @(posedge clock);
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= d;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (idx == CSR_CRYSTAL) crystal_hz = d[XTAL_W-1:0];
      else target_hz = d;
   endtask

   always @(posedge clock) begin
      csp_word_type w;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_writes.size() == 0) begin
            report_mismatch("unexpected word addr", rsp_reg_addr, 0);
         end else begin
            w = pending_writes.pop_front();
            if (rsp_reg_addr != w.addr) report_mismatch("reg_addr", rsp_reg_addr, w.addr);
            if (rsp_reg_data != w.data) report_mismatch("reg_data", rsp_reg_data, w.data);
            if (rsp_last_write != w.last)
               report_mismatch("last_write", rsp_last_write, w.last);
            if (rsp_range_error != w.err)
               report_mismatch("range_error", rsp_range_error, w.err);
         end
      end
      rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic test_directed();
      send_freq(32'd0);
      send_freq(32'd1);
      send_freq(32'hFFFF_FFFF);
      send_freq(32'd225_000_000);
      send_freq(32'd225_000_001);
      send_freq(32'd439_453);
      send_freq(32'd439_452);
      send_freq(32'd439_000);
      send_freq(32'd128_571_428);
      send_freq(32'd10_000_000);
      send_freq(32'd7_000_000);
      send_freq(32'd14_318_180);
      send_freq(32'h8000_0000);
      send_freq(32'h5555_5555);
      send_freq(32'h0AAA_AAAA);
   endtask

   task automatic test_config_extremes();
      write_csr(CSR_CRYSTAL, 30'd10_000_000);
      write_csr(CSR_TARGET, 30'd600_000_000);
      send_freq(32'd150_000_000);
      send_freq(32'd292_969);
      send_freq(32'd33_333_333);
      write_csr(CSR_CRYSTAL, 30'd40_000_000);
      write_csr(CSR_TARGET, 30'h3FFF_FFFF);
      send_freq(32'd268_435_455);
      send_freq(32'd524_288);
      send_freq(32'd3_000_001);
      write_csr(CSR_CRYSTAL, 30'd0);
      send_freq(32'd10_000_000);
      write_csr(CSR_CRYSTAL, 30'h3FF_FFFF);
      send_freq(32'd12_345_678);
      write_csr(CSR_CRYSTAL, 30'd1000);
      send_freq(32'd1_000_003);
      write_csr(CSR_CRYSTAL, 30'd900_000_000 >> 6);
      send_freq(32'd200_000_000);
   endtask

   task automatic test_random_phase(input int n_items, input int s_pct, input int r_pct);
      logic [31:0] lo, hi, f;
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      write_csr(CSR_CRYSTAL, 30'($urandom_range(40_000_000, 10_000_000)));
      write_csr(CSR_TARGET, 30'($urandom_range(900_000_000, 600_000_000)));
      lo = target_hz / 2049 + 1;
      hi = target_hz / 4;
      for (int i = 0; i < n_items; i++) begin
         if ($urandom_range(99) < 80) f = $urandom_range(hi, lo);
         else if ($urandom_range(1)) f = $urandom;
         else f = $urandom_range(lo + 2, 0);
         send_freq(f);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 15;
      recv_idle_pct = 67;
      test_directed();
      test_config_extremes();
      test_random_phase(115, 15, 67);
      test_random_phase(115, 67, 15);
      test_random_phase(115, 0, 0);
      req_push <= 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

   initial begin
      #6_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
`default_nettype wire

// ----- clock_synth_register_planner_top.f -----
rtl/csp_pkg.sv
rtl/csp_div.sv
rtl/csp_front.sv
rtl/csp_queue.sv
rtl/csp_back.sv
rtl/clock_synth_register_planner_top.sv
tb/tb_top.sv
